[rtl/object_name_allocator_top_defines.svh]
// assertion macros shared by the allocator checker
`ifndef OBJECT_NAME_ALLOCATOR_TOP_DEFINES_SVH
`define OBJECT_NAME_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define ONA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define ONA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ona_pkg.sv]
// shared types, codes and defaults of the object name allocator
`default_nettype none

package ona_pkg;

  // default sizes
  localparam int unsigned NAME_COUNT_DEF = 1024;
  localparam int unsigned MAX_BATCH_DEF  = 16;

  // field widths
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned NAME_W   = 10;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;

  // request operations
  typedef enum logic [MODE_W-1:0] {
    MODE_GENERATE = 3'd0,
    MODE_INSERT   = 3'd1,
    MODE_RELEASE  = 3'd2,
    MODE_QUERY    = 3'd3,
    MODE_CLEAR    = 3'd4
  } mode_e;

  // response status codes
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_STACK_FULL = 2'd2;

  // request payload
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [NAME_W-1:0]  name_in;
    logic [COUNT_W-1:0] count;
  } in_req_t;

  // response payload
  typedef struct packed {
    logic [NAME_W-1:0]   name_out;
    logic                flag;
    logic                last;
    logic [STATUS_W-1:0] status;
  } out_rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic clr_start;
    logic clr_step;
    logic pop;
    logic gen_emit;
    logic pop_emit;
    logic decide_emit;
    logic clr_emit;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
    logic stack_nonempty;
    logic last_name;
    logic sweep_done;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/ona_ctrl.sv]
// sequencer of the object name allocator
`default_nettype none

module ona_ctrl import ona_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire in_req_t    in_req_i,
  output logic            in_stall_o,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  typedef enum logic [6:0] {
    ST_SWEEP   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_GEN     = 7'b0000100,
    ST_POP     = 7'b0001000,
    ST_LOOK    = 7'b0010000,
    ST_DECIDE  = 7'b0100000,
    ST_CLR_RSP = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   report_q, report_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    report_d   = report_q;
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_SWEEP: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.sweep_done) begin
          state_d = report_q ? ST_CLR_RSP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (in_req_i.mode)
            MODE_GENERATE: begin
              if (in_req_i.count != '0) begin
                state_d = ST_GEN;
              end
            end
            MODE_INSERT, MODE_RELEASE, MODE_QUERY: begin
              state_d = ST_LOOK;
            end
            MODE_CLEAR: begin
              cmd_o.clr_start = 1'b1;
              report_d        = 1'b1;
              state_d         = ST_SWEEP;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_GEN: begin
        if (status_i.stack_nonempty) begin
          cmd_o.pop = 1'b1;
          state_d   = ST_POP;
        end else if (status_i.out_free) begin
          cmd_o.gen_emit = 1'b1;
          if (status_i.last_name) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_POP: begin
        if (status_i.out_free) begin
          cmd_o.pop_emit = 1'b1;
          state_d        = status_i.last_name ? ST_IDLE : ST_GEN;
        end
      end
      ST_LOOK: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status_i.out_free) begin
          cmd_o.decide_emit = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_CLR_RSP: begin
        if (status_i.out_free) begin
          cmd_o.clr_emit = 1'b1;
          report_d       = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state registers, sweep the live map out of reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_SWEEP;
      report_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      report_q <= report_d;
    end
  end

endmodule

`default_nettype wire

[rtl/ona_datapath.sv]
// live map, free stack, counters and response register of the allocator
`default_nettype none

module ona_datapath import ona_pkg::*; #(
  parameter int unsigned NAME_COUNT = NAME_COUNT_DEF,
  parameter int unsigned MAX_BATCH  = MAX_BATCH_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire in_req_t in_req_i,
  input  wire dp_cmd_t cmd_i,
  output dp_status_t   status_o,
  input  wire logic    out_stall_i,
  output logic         out_valid_o,
  output out_rsp_t     out_rsp_o
);

  localparam int unsigned AW = $clog2(NAME_COUNT);
  localparam int unsigned FW = $clog2(NAME_COUNT + 1);
  localparam int unsigned CW = $clog2(MAX_BATCH + 1);

  // captured request
  logic [MODE_W-1:0] mode_q;
  logic [NAME_W-1:0] name_q;
  logic [CW-1:0]     count_q;
  logic [CW-1:0]     idx_q;
  logic [CW-1:0]     idx_next;
  logic [CW-1:0]     count_sat;

  // allocator state
  logic [FW-1:0] free_count_q;
  logic [FW-1:0] free_dec;
  logic [FW-1:0] next_fresh_q;
  logic [AW-1:0] sweep_q;

  // memories and their read registers
  logic              live_mem [NAME_COUNT];
  logic [NAME_W-1:0] stack_mem [NAME_COUNT];
  logic              live_rd_q;
  logic [NAME_W-1:0] stk_rd_q;

  // live map write port
  logic          live_we;
  logic [AW-1:0] live_wa;
  logic          live_wd;

  // decisions
  logic          in_range;
  logic          live_hit;
  logic          fresh_avail;
  logic          stack_room;
  logic          ins_new;
  logic          rel_do;
  logic          rel_push;
  logic          emit;
  logic [AW-1:0] name_addr;

  // response register
  logic     out_valid_q;
  out_rsp_t out_q;
  out_rsp_t rsp_d;

  // request decode
  assign count_sat   = (32'(in_req_i.count) > MAX_BATCH) ? CW'(MAX_BATCH)
                                                          : CW'(in_req_i.count);
  assign idx_next    = idx_q + 1'b1;
  assign free_dec    = free_count_q - 1'b1;
  assign in_range    = 32'(name_q) < NAME_COUNT;
  assign name_addr   = AW'(name_q);
  assign live_hit    = in_range && live_rd_q;
  assign fresh_avail = next_fresh_q < FW'(NAME_COUNT);
  assign stack_room  = free_count_q < FW'(NAME_COUNT);
  assign ins_new     = (mode_q == MODE_INSERT) && in_range && !live_rd_q;
  assign rel_do      = (mode_q == MODE_RELEASE) && (name_q != '0) && live_hit;
  assign rel_push    = rel_do && stack_room;
  assign emit        = cmd_i.gen_emit | cmd_i.pop_emit | cmd_i.decide_emit | cmd_i.clr_emit;

  // status to the sequencer
  assign status_o.out_free       = !out_valid_q || !out_stall_i;
  assign status_o.stack_nonempty = (free_count_q != '0);
  assign status_o.last_name      = (idx_next == count_q);
  assign status_o.sweep_done     = (sweep_q == AW'(NAME_COUNT - 1));

  // live map write select
  always_comb begin
    live_we = 1'b0;
    live_wa = name_addr;
    live_wd = 1'b0;
    if (cmd_i.clr_step) begin
      live_we = 1'b1;
      live_wa = sweep_q;
    end else if (cmd_i.gen_emit && fresh_avail) begin
      live_we = 1'b1;
      live_wa = next_fresh_q[AW-1:0];
      live_wd = 1'b1;
    end else if (cmd_i.pop_emit) begin
      live_we = 1'b1;
      live_wa = AW'(stk_rd_q);
      live_wd = 1'b1;
    end else if (cmd_i.decide_emit && ins_new) begin
      live_we = 1'b1;
      live_wd = 1'b1;
    end else if (cmd_i.decide_emit && rel_do) begin
      live_we = 1'b1;
    end
  end

  // live map memory
  always_ff @(posedge clk_i) begin
    if (live_we) begin
      live_mem[live_wa] <= live_wd;
    end
    live_rd_q <= live_mem[name_addr];
  end

  // free stack memory, read on pop only
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide_emit && rel_push) begin
      stack_mem[free_count_q[AW-1:0]] <= name_q;
    end
    if (cmd_i.pop) begin
      stk_rd_q <= stack_mem[free_dec[AW-1:0]];
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q  <= in_req_i.mode;
      name_q  <= in_req_i.name_in;
      count_q <= count_sat;
    end
  end

  // counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_count_q <= '0;
      next_fresh_q <= FW'(1);
      sweep_q      <= '0;
      idx_q        <= '0;
    end else begin
      if (cmd_i.clr_start) begin
        free_count_q <= '0;
      end else if (cmd_i.pop) begin
        free_count_q <= free_dec;
      end else if (cmd_i.decide_emit && rel_push) begin
        free_count_q <= free_count_q + 1'b1;
      end
      if (cmd_i.clr_start) begin
        next_fresh_q <= FW'(1);
      end else if (cmd_i.gen_emit && fresh_avail) begin
        next_fresh_q <= next_fresh_q + 1'b1;
      end
      if (cmd_i.clr_start) begin
        sweep_q <= '0;
      end else if (cmd_i.clr_step) begin
        sweep_q <= sweep_q + 1'b1;
      end
      if (cmd_i.capture) begin
        idx_q <= '0;
      end else if (cmd_i.gen_emit || cmd_i.pop_emit) begin
        idx_q <= idx_next;
      end
    end
  end

  // response build
  always_comb begin
    rsp_d = '0;
    if (cmd_i.gen_emit) begin
      rsp_d.name_out = fresh_avail ? NAME_W'(next_fresh_q) : '0;
      rsp_d.status   = fresh_avail ? STATUS_OK : STATUS_EXHAUSTED;
      rsp_d.last     = status_o.last_name;
    end else if (cmd_i.pop_emit) begin
      rsp_d.name_out = stk_rd_q;
      rsp_d.last     = status_o.last_name;
    end else if (cmd_i.decide_emit) begin
      rsp_d.flag   = ins_new || ((mode_q == MODE_QUERY) && live_hit);
      rsp_d.status = (rel_do && !stack_room) ? STATUS_STACK_FULL : STATUS_OK;
      rsp_d.last   = 1'b1;
    end else begin
      rsp_d.last = 1'b1;
    end
  end

  // response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // response payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

[rtl/object_name_allocator_top.sv]
// top level of the object name allocator
`default_nettype none

// Object name allocator. Hands out names 1..NAME_COUNT-1 from a LIFO stack of
// released names, falling back to a fresh counter, and keeps a live bit per
// name in a single-port-write, registered-read memory. One request is worked
// at a time. A generate request is accepted, then takes each name from the
// counter directly or pops it from the free stack, the stack read being an
// extra step. Insert, release and query go through accept, live map read,
// and update and respond. Clear sweeps the live map one entry per cycle and
// responds after it; the same sweep runs after reset, and no request is taken
// while it runs. Responses sit in an output register, so a stalled consumer
// holds back only the step that would produce the next response.

module object_name_allocator_top import ona_pkg::*; #(
  parameter int unsigned NAME_COUNT = NAME_COUNT_DEF,
  parameter int unsigned MAX_BATCH  = MAX_BATCH_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire in_req_t in_req_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output out_rsp_t     out_rsp_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  ona_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // storage and response path
  ona_datapath #(
    .NAME_COUNT (NAME_COUNT),
    .MAX_BATCH  (MAX_BATCH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

[rtl/ona_checker.sv]
// port-level assertions of the object name allocator and their binding
`default_nettype none

`include "object_name_allocator_top_defines.svh"

module ona_checker import ona_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire in_req_t  in_req_i,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire out_rsp_t out_rsp_o
);

  logic unused_in;
  assign unused_in = in_valid_i ^ in_stall_o ^ (^in_req_i);

  // a stalled response holds
  `ONA_ASSERT_NEXT(a_rsp_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_rsp_o), "stalled response changed")

  // exhaustion never carries a name
  `ONA_ASSERT_SAME(a_exhaust_zero, out_valid_o && (out_rsp_o.status == STATUS_EXHAUSTED), out_rsp_o.name_out == '0, "exhausted response carries a name")

  // a set flag comes from insert or query only
  `ONA_ASSERT_SAME(a_flag_clean, out_valid_o && out_rsp_o.flag, (out_rsp_o.name_out == '0) && (out_rsp_o.status == STATUS_OK) && out_rsp_o.last, "flag on a generate or failed response")

  // a full stack is reported on the single release response
  `ONA_ASSERT_SAME(a_full_single, out_valid_o && (out_rsp_o.status == STATUS_STACK_FULL), out_rsp_o.last && !out_rsp_o.flag && (out_rsp_o.name_out == '0), "stack full on a non-release response")

endmodule

bind object_name_allocator_top ona_checker u_checker (.*);

`default_nettype wire

[bench/tb_top.sv]
// testbench for the object name allocator: directed and random requests checked against a predictor
`default_nettype none

module tb_top;
  import ona_pkg::*;

  localparam int unsigned NAME_COUNT   = NAME_COUNT_DEF;
  localparam int unsigned MAX_BATCH    = MAX_BATCH_DEF;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned RANDOM_ITEMS = 256;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RECENT_MAX   = 48;
  localparam int unsigned PRINT_MAX    = 40;

  // expected responses and a private copy of the allocator state
  class alloc_scoreboard;
    bit                live_map   [NAME_COUNT];
    bit   [NAME_W-1:0] free_stack [NAME_COUNT];
    int unsigned       free_count;
    int unsigned       next_fresh;
    out_rsp_t          pending_rsp [$];
    logic [NAME_W-1:0] recent_names [$];
    int unsigned       mismatches;
    int unsigned       accepted;
    int unsigned       responses_checked;
    int unsigned       exhausted_seen;
    int unsigned       stack_full_seen;
    int unsigned       clears_seen;

    function new();
      wipe_state();
      mismatches        = 0;
      accepted          = 0;
      responses_checked = 0;
      exhausted_seen    = 0;
      stack_full_seen   = 0;
      clears_seen       = 0;
    endfunction

    function void wipe_state();
      foreach (live_map[i]) begin
        live_map[i]   = 1'b0;
        free_stack[i] = '0;
      end
      free_count = 0;
      next_fresh = 1;
      recent_names.delete();
    endfunction

    // remember handed-out names so later requests can target them
    function void remember(logic [NAME_W-1:0] nm);
      recent_names = {recent_names, nm};
      if (recent_names.size() > RECENT_MAX) recent_names.delete(0);
    endfunction

    // queue one expected response behind the others
    function void expect_rsp(out_rsp_t rsp);
      pending_rsp = {pending_rsp, rsp};
    endfunction

    // work out the responses one accepted request causes
    function void note_request(in_req_t r);
      out_rsp_t    rsp;
      int unsigned n;
      bit          in_range;
      accepted++;
      in_range = (r.name_in < NAME_COUNT);
      rsp      = '0;
      rsp.last = 1'b1;
      case (r.mode)
        MODE_GENERATE: begin
          n = (r.count > MAX_BATCH) ? MAX_BATCH : r.count;
          for (int k = 0; k < n; k++) begin
            rsp = '0;
            if (free_count > 0) begin
              free_count--;
              rsp.name_out = free_stack[free_count];
              live_map[rsp.name_out] = 1'b1;
              remember(rsp.name_out);
            end else if (next_fresh < NAME_COUNT) begin
              rsp.name_out = NAME_W'(next_fresh);
              next_fresh++;
              live_map[rsp.name_out] = 1'b1;
              remember(rsp.name_out);
            end else begin
              rsp.status = STATUS_EXHAUSTED;
              exhausted_seen++;
            end
            rsp.last = (k == n - 1);
            expect_rsp(rsp);
          end
        end
        MODE_INSERT: begin
          if (in_range && !live_map[r.name_in]) begin
            live_map[r.name_in] = 1'b1;
            rsp.flag = 1'b1;
          end
          expect_rsp(rsp);
        end
        MODE_RELEASE: begin
          if (r.name_in != 0 && in_range && live_map[r.name_in]) begin
            live_map[r.name_in] = 1'b0;
            if (free_count < NAME_COUNT) begin
              free_stack[free_count] = r.name_in;
              free_count++;
            end else begin
              rsp.status = STATUS_STACK_FULL;
              stack_full_seen++;
            end
          end
          expect_rsp(rsp);
        end
        MODE_QUERY: begin
          rsp.flag = in_range && live_map[r.name_in];
          expect_rsp(rsp);
        end
        MODE_CLEAR: begin
          wipe_state();
          clears_seen++;
          expect_rsp(rsp);
        end
        default: begin
          // modes above clear are dropped by the block
        end
      endcase
    endfunction

    task report(string what);
      if (mismatches < PRINT_MAX) $display("mismatch: %s", what);
      mismatches++;
    endtask

    // compare one accepted response with the oldest expectation
    task check_response(out_rsp_t got);
      out_rsp_t want;
      if (pending_rsp.size() == 0) begin
        report($sformatf("unexpected response name %0d flag %0b last %0b status %0d",
                         got.name_out, got.flag, got.last, got.status));
        return;
      end
      want = pending_rsp[0];
      pending_rsp.delete(0);
      responses_checked++;
      if (got.name_out !== want.name_out)
        report($sformatf("response %0d name_out %0d, want %0d",
                         responses_checked, got.name_out, want.name_out));
      if (got.flag !== want.flag)
        report($sformatf("response %0d flag %0b, want %0b",
                         responses_checked, got.flag, want.flag));
      if (got.last !== want.last)
        report($sformatf("response %0d last %0b, want %0b",
                         responses_checked, got.last, want.last));
      if (got.status !== want.status)
        report($sformatf("response %0d status %0d, want %0d",
                         responses_checked, got.status, want.status));
    endtask
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  in_req_t  in_req_i;
  logic     out_valid_o;
  logic     out_stall_i;
  out_rsp_t out_rsp_o;

  alloc_scoreboard sb = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          start_hold     = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned cycles         = 0;

  object_name_allocator_top #(
    .NAME_COUNT (NAME_COUNT),
    .MAX_BATCH  (MAX_BATCH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycles, sb.pending_rsp.size());
        $display("** object_name_allocator_top: FAILED **");
        $finish;
      end
    end
  end

  // response side: check accepted responses, stall at random or for a long hold
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) sb.check_response(out_rsp_o);
      if (start_hold) begin
        start_hold = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  function automatic in_req_t make_req(mode_e m, int unsigned nm, int unsigned cnt);
    in_req_t r;
    r.mode    = m;
    r.name_in = NAME_W'(nm);
    r.count   = COUNT_W'(cnt);
    return r;
  endfunction

  // offer one request, idling first at random, and wait until it is taken
  task automatic send_req(in_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(r);
  endtask

  // mostly names that were handed out recently, sometimes any name
  function automatic logic [NAME_W-1:0] pick_name();
    if (sb.recent_names.size() == 0 || $urandom_range(99) < 25)
      return NAME_W'($urandom_range(NAME_COUNT - 1));
    return sb.recent_names[$urandom_range(sb.recent_names.size() - 1)];
  endfunction

  function automatic in_req_t random_req();
    in_req_t     r;
    int unsigned roll;
    r.mode    = MODE_GENERATE;
    r.name_in = NAME_W'($urandom_range(NAME_COUNT - 1));
    r.count   = COUNT_W'($urandom_range(31));
    roll      = $urandom_range(99);
    if (roll < 30) begin
      if (roll < 20)      r.count = COUNT_W'($urandom_range(1, 4));
      else if (roll < 27) r.count = COUNT_W'($urandom_range(5, MAX_BATCH));
    end else if (roll < 52) begin
      r.mode    = MODE_RELEASE;
      r.name_in = pick_name();
    end else if (roll < 67) begin
      r.mode    = MODE_INSERT;
      r.name_in = pick_name();
    end else if (roll < 88) begin
      r.mode    = MODE_QUERY;
      r.name_in = pick_name();
    end else if (roll < 90) begin
      r.mode = MODE_CLEAR;
    end else if (roll < 93) begin
      r.mode = 3'($urandom_range(5, 7));
    end else begin
      // a few more releases of recent names
      r.mode    = MODE_RELEASE;
      r.name_in = pick_name();
    end
    return r;
  endfunction

  // random requests until the given number of effective ones has been taken
  task automatic run_random(int unsigned items);
    in_req_t     r;
    int unsigned done;
    done = 0;
    while (done < items) begin
      r = random_req();
      send_req(r);
      if (!(r.mode > MODE_CLEAR || (r.mode == MODE_GENERATE && r.count == 0))) done++;
    end
  endtask

  // stimulus
  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_req_i   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, every mode, special cases
    send_req(make_req(MODE_QUERY, 0, 0));
    send_req(make_req(MODE_GENERATE, 0, 1));
    send_req(make_req(MODE_GENERATE, 1023, 16));
    send_req(make_req(MODE_GENERATE, 0, 0));          // count zero
    send_req(make_req(MODE_GENERATE, 0, 31));         // count saturates
    send_req(make_req(MODE_INSERT, 1, 0));            // already live
    send_req(make_req(MODE_INSERT, 1023, 31));        // above the counter
    send_req(make_req(MODE_QUERY, 1023, 0));
    send_req(make_req(MODE_RELEASE, 0, 0));           // name zero ignored
    send_req(make_req(MODE_RELEASE, 500, 0));         // not live, ignored
    send_req(make_req(MODE_RELEASE, 5, 0));
    send_req(make_req(MODE_RELEASE, 9, 0));
    send_req(make_req(MODE_GENERATE, 0, 3));          // lifo pops, then counter
    send_req(make_req(MODE_RELEASE, 12, 0));
    send_req(make_req(MODE_INSERT, 12, 0));           // name on the free stack
    send_req(make_req(MODE_GENERATE, 0, 1));          // hands it out again
    send_req(make_req(MODE_QUERY, 12, 0));
    send_req(make_req(mode_e'(3'd5), 1023, 31));      // unused modes
    send_req(make_req(mode_e'(3'd6), 0, 0));
    send_req(make_req(mode_e'(3'd7), 682, 21));
    send_req(make_req(MODE_CLEAR, 341, 10));
    send_req(make_req(MODE_QUERY, 1, 0));
    send_req(make_req(MODE_GENERATE, 0, 2));

    // exhaust the counter, then recycle a few names through the free stack
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    send_req(make_req(MODE_CLEAR, 0, 0));
    repeat (NAME_COUNT / MAX_BATCH) send_req(make_req(MODE_GENERATE, 0, MAX_BATCH));
    send_req(make_req(MODE_GENERATE, 0, 3));
    for (int unsigned nm = 1; nm <= 8; nm++) send_req(make_req(MODE_RELEASE, nm, 0));
    send_req(make_req(MODE_INSERT, 7, 0));            // name on the free stack
    send_req(make_req(MODE_RELEASE, 7, 0));           // pushed a second time
    send_req(make_req(MODE_GENERATE, 0, MAX_BATCH));  // pops, then exhausted
    send_req(make_req(MODE_CLEAR, 0, 0));

    // random phases: no idling with a long receiver hold, then idling mixes
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    start_hold     = 1'b1;
    run_random(RANDOM_ITEMS / 4);
    send_idle_pct  = 46;
    recv_stall_pct = 0;
    run_random(RANDOM_ITEMS / 4);
    send_idle_pct  = 0;
    recv_stall_pct = 46;
    run_random(RANDOM_ITEMS / 4);
    send_idle_pct  = 19;
    recv_stall_pct = 19;
    run_random(RANDOM_ITEMS / 4);

    // drain
    in_valid_i <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d requests and %0d responses in %0d cycles",
             sb.accepted, sb.responses_checked, cycles);
    $display("exhausted results %0d, stack full results %0d, clears %0d",
             sb.exhausted_seen, sb.stack_full_seen, sb.clears_seen);
    if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
      $display("** object_name_allocator_top: PASSED **");
    end else begin
      $display("** object_name_allocator_top: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
